// ===== src/hbq_pkg.sv =====
// Shared definitions for the binary min-heap queue: default sizes, operation
// and status codes, and the sequencer state type.
// Depends on nothing; the top module, the comparator and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package hbq_pkg;

	localparam int HBQ_DEPTH     = 1024;
	localparam int HBQ_NODE_BITS = 16;
	localparam int KEY_W         = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_UP   = 6'b000010,
		S_RM   = 6'b000100,
		S_SEL  = 6'b001000,
		S_CMP  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// ===== src/binary_min_heap_queue.sv =====
// Binary min-heap priority queue over one shared comparator and a two-read entry memory.
// Busy stays high through the sift-up compares of an insert, one parent per compare, and
// the read, select and compare states of a remove, each ended by a final write state; done
// rises as busy falls, when the next item may already be accepted. A full or empty refusal
// keeps busy low and gives done in the cycle after the start.
// The receiver cannot stall; asynchronous reset empties the heap, the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue #(
	parameter int DEPTH     = hbq_pkg::HBQ_DEPTH,
	parameter int NODE_BITS = hbq_pkg::HBQ_NODE_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output      logic                             busy,
	input  wire logic                             operation,
	input  wire logic [hbq_pkg::KEY_W-1:0]        key,
	input  wire logic [NODE_BITS-1:0]             node_a,
	input  wire logic [NODE_BITS-1:0]             node_b,
	output      logic                             done,
	output      logic [hbq_pkg::KEY_W-1:0]        out_key,
	output      logic [NODE_BITS-1:0]             out_node_a,
	output      logic [NODE_BITS-1:0]             out_node_b,
	output      logic [1:0]                       status,
	output      logic [$clog2(DEPTH+1)-1:0]       count
);

	import hbq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = KEY_W + 2 * NODE_BITS;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic done_q;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] par_q;
	logic [AW-1:0] pick_idx_q;
	logic right_ok_q;
	logic [EW-1:0] cur_q;
	logic [EW-1:0] pick_q;
	logic [KEY_W-1:0] res_key_q;
	logic [NODE_BITS-1:0] res_a_q;
	logic [NODE_BITS-1:0] res_b_q;
	status_t res_st_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] mem_ra0;
	logic [AW-1:0] mem_ra1;
	logic [EW-1:0] mem_rd0;
	logic [EW-1:0] mem_rd1;

	logic [KEY_W-1:0] cmp_a;
	logic [KEY_W-1:0] cmp_b;
	logic cmp_gt;

	logic accept;
	logic is_full;
	logic is_empty;
	logic [AW-1:0] ins_pos;
	logic [AW-1:0] up_src;
	logic [AW-1:0] up_par;
	logic [AW-1:0] dn_src;
	logic [AW:0] left_w;
	logic [AW:0] right_w;
	logic [AW:0] n_ext;
	logic left_in;
	logic right_in;
	logic [CW-1:0] last_w;
	logic pick_right;
	logic [AW:0] sel_left_w;
	logic [AW:0] sel_right_w;

	hbq_mem #(
		.DEPTH(DEPTH),
		.WIDTH(EW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr0(mem_ra0),
		.raddr1(mem_ra1),
		.rdata0(mem_rd0),
		.rdata1(mem_rd1)
	);

	hbq_cmp u_cmp (
		.a(cmp_a),
		.b(cmp_b),
		.gt(cmp_gt)
	);

	assign accept   = start && (state_q == S_IDLE);
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign ins_pos  = count_q[AW-1:0];
	assign last_w   = count_q - CW'(1);

	// Parent index of the hole during sift-up.
	assign up_src = (state_q == S_IDLE) ? ins_pos : par_q;
	assign up_par = (up_src - AW'(1)) >> 1;

	// Child indexes of the hole during sift-down, checked against the count.
	assign dn_src   = (state_q == S_RM) ? '0 : pick_idx_q;
	assign left_w   = {dn_src, 1'b1};
	assign right_w  = {dn_src, 1'b0} + (AW+1)'(2);
	assign n_ext    = (AW+1)'(count_q);
	assign left_in  = left_w < n_ext;
	assign right_in = right_w < n_ext;

	// In the select state the children belong to the current hole.
	// dn_src then holds the previous pick, so recompute from pos_q there.
	assign sel_left_w  = {pos_q, 1'b1};
	assign sel_right_w = {pos_q, 1'b0} + (AW+1)'(2);

	assign pick_right = right_ok_q && cmp_gt;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = cur_q;
		mem_ra0   = left_w[AW-1:0];
		mem_ra1   = right_w[AW-1:0];
		cmp_a     = cur_q[EW-1 -: KEY_W];
		cmp_b     = pick_q[EW-1 -: KEY_W];
		unique case (state_q)
			S_IDLE: begin
				if (operation == OP_REMOVE) begin
					mem_ra0 = '0;
					mem_ra1 = last_w[AW-1:0];
				end else begin
					mem_ra0 = up_par;
				end
			end
			S_UP: begin
				mem_ra0 = up_par;
				cmp_a   = mem_rd0[EW-1 -: KEY_W];
				cmp_b   = cur_q[EW-1 -: KEY_W];
				if (cmp_gt) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rd0;
				end
			end
			S_RM: begin
			end
			S_SEL: begin
				cmp_a = mem_rd0[EW-1 -: KEY_W];
				cmp_b = mem_rd1[EW-1 -: KEY_W];
			end
			S_CMP: begin
				if (cmp_gt) begin
					mem_we    = 1'b1;
					mem_wdata = pick_q;
				end
			end
			S_FIN: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_INSERT) begin
							if (is_full) begin
								done_q <= 1'b1;
							end else begin
								count_q <= count_q + CW'(1);
								state_q <= is_empty ? S_FIN : S_UP;
							end
						end else begin
							if (is_empty) begin
								done_q <= 1'b1;
							end else begin
								count_q <= last_w;
								state_q <= S_RM;
							end
						end
					end
				end
				S_UP: begin
					if (!cmp_gt || par_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_RM: begin
					state_q <= left_in ? S_SEL : S_FIN;
				end
				S_SEL: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= (cmp_gt && left_in) ? S_SEL : S_FIN;
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_key_q <= '0;
					res_a_q   <= '0;
					res_b_q   <= '0;
					if (operation == OP_INSERT) begin
						res_st_q <= is_full ? ST_FULL : ST_OK;
						cur_q    <= {key, node_a, node_b};
						pos_q    <= ins_pos;
						par_q    <= up_par;
					end else begin
						res_st_q <= is_empty ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_UP: begin
				if (cmp_gt) begin
					pos_q <= par_q;
					par_q <= up_par;
				end
			end
			S_RM: begin
				res_key_q  <= mem_rd0[EW-1 -: KEY_W];
				res_a_q    <= mem_rd0[2*NODE_BITS-1:NODE_BITS];
				res_b_q    <= mem_rd0[NODE_BITS-1:0];
				cur_q      <= mem_rd1;
				pos_q      <= '0;
				right_ok_q <= right_in;
			end
			S_SEL: begin
				if (pick_right) begin
					pick_q     <= mem_rd1;
					pick_idx_q <= sel_right_w[AW-1:0];
				end else begin
					pick_q     <= mem_rd0;
					pick_idx_q <= sel_left_w[AW-1:0];
				end
			end
			S_CMP: begin
				if (cmp_gt) begin
					pos_q      <= pick_idx_q;
					right_ok_q <= right_in;
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign out_key    = res_key_q;
	assign out_node_a = res_a_q;
	assign out_node_b = res_b_q;
	assign status     = res_st_q;
	assign count      = count_q;

endmodule

`default_nettype wire

// ===== src/hbq_mem.sv =====
// Heap entry storage: one write port and two read ports with registered
// read data. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module hbq_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output      logic [WIDTH-1:0]         rdata0,
	output      logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

`default_nettype wire

// ===== src/hbq_cmp.sv =====
// Shared key comparator: tells whether one signed key is strictly greater
// than another. Depends on hbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbq_cmp (
	input  wire logic [hbq_pkg::KEY_W-1:0] a,
	input  wire logic [hbq_pkg::KEY_W-1:0] b,
	output      logic                      gt
);

	import hbq_pkg::*;

	assign gt = $signed(a) > $signed(b);

endmodule

`default_nettype wire

// ===== tb/tb_binary_min_heap_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for binary_min_heap_queue: a scoreboard class keeps its own heap
// and compares every result strobe with the oldest expected result.
// Depends on hbq_pkg and the binary_min_heap_queue RTL.

module tb_binary_min_heap_queue;
	import hbq_pkg::*;

	localparam int NB             = HBQ_NODE_BITS;
	localparam int CNT_W          = $clog2(HBQ_DEPTH + 1);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 30;
	localparam int RANDOM_ITEMS   = 450;

	typedef struct packed {
		logic [KEY_W-1:0] k;
		logic [NB-1:0]    a;
		logic [NB-1:0]    b;
	} heap_entry_t;

	typedef struct packed {
		heap_entry_t      e;
		status_t          st;
		logic [CNT_W-1:0] n;
	} heap_result_t;

	class heap_scoreboard;
		heap_entry_t  slots[HBQ_DEPTH];
		int           held;
		int           errors;
		int           checked;
		heap_result_t awaited[$];

		function new();
			held    = 0;
			errors  = 0;
			checked = 0;
		endfunction

		function bit heavier(heap_entry_t x, heap_entry_t y);
			return $signed(x.k) > $signed(y.k);
		endfunction

		function void trade(int i, int j);
			heap_entry_t t;
			t        = slots[i];
			slots[i] = slots[j];
			slots[j] = t;
		endfunction

		function void note_item(op_t op, logic [KEY_W-1:0] k, logic [NB-1:0] a,
				logic [NB-1:0] b);
			heap_result_t r;
			int pos;
			int up;
			int left;
			int pick;
			r = '0;
			if (op == OP_INSERT) begin
				if (held >= HBQ_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					r.st = ST_OK;
					pos = held;
					slots[pos] = {k, a, b};
					held++;
					while (pos > 0) begin
						up = (pos - 1) / 2;
						if (!heavier(slots[up], slots[pos]))
							break;
						trade(up, pos);
						pos = up;
					end
				end
			end else if (held == 0) begin
				r.st = ST_EMPTY;
			end else begin
				r.st = ST_OK;
				r.e = slots[0];
				held--;
				slots[0] = slots[held];
				pos = 0;
				while (2 * pos + 1 < held) begin
					left = 2 * pos + 1;
					pick = left;
					if (left + 1 < held && heavier(slots[left], slots[left + 1]))
						pick = left + 1;
					if (!heavier(slots[pos], slots[pick]))
						break;
					trade(pos, pick);
					pos = pick;
				end
			end
			r.n = CNT_W'(held);
			awaited.push_back(r);
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [KEY_W-1:0] k, logic [NB-1:0] a, logic [NB-1:0] b,
				logic [1:0] st, logic [CNT_W-1:0] n);
			heap_result_t w;
			if (awaited.size() == 0) begin
				report($sformatf("result with no item pending, key %0d", $signed(k)));
			end else begin
				w = awaited.pop_front();
				if (k !== w.e.k)
					report($sformatf("result %0d out_key %0d, expected %0d", checked,
						$signed(k), $signed(w.e.k)));
				if (a !== w.e.a)
					report($sformatf("result %0d out_node_a %h, expected %h", checked, a, w.e.a));
				if (b !== w.e.b)
					report($sformatf("result %0d out_node_b %h, expected %h", checked, b, w.e.b));
				if (st !== w.st)
					report($sformatf("result %0d status %0d, expected %0d", checked, st, w.st));
				if (n !== w.n)
					report($sformatf("result %0d count %0d, expected %0d", checked, n, w.n));
			end
			checked++;
		endtask
	endclass

	logic             clk;
	logic             arst_n     = 1'b0;
	logic             start      = 1'b0;
	logic             operation  = 1'b0;
	logic [KEY_W-1:0] key        = '0;
	logic [NB-1:0]    node_a     = '0;
	logic [NB-1:0]    node_b     = '0;
	logic             busy;
	logic             done;
	logic [KEY_W-1:0] out_key;
	logic [NB-1:0]    out_node_a;
	logic [NB-1:0]    out_node_b;
	logic [1:0]       status;
	logic [CNT_W-1:0] count;

	heap_scoreboard sb = new();
	bit             steady = 1'b0;
	int             stall_cycles = 0;

	binary_min_heap_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.node_a     (node_a),
		.node_b     (node_b),
		.done       (done),
		.out_key    (out_key),
		.out_node_a (out_node_a),
		.out_node_b (out_node_b),
		.status     (status),
		.count      (count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(out_key, out_node_a, out_node_b, status, count);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [KEY_W-1:0] random_key();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return KEY_W'($urandom_range(0, 7)) - KEY_W'(4);
		if (sel < 9)
			return KEY_W'($urandom());
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic put_item(op_t op, logic [KEY_W-1:0] k, logic [NB-1:0] a, logic [NB-1:0] b);
		if (!steady && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 1) != 0) ? 3 : 26))
				@(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		key       <= k;
		node_a    <= a;
		node_b    <= b;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(op, k, a, b);
	endtask

	task automatic put_random_item(int remove_pct);
		op_t op;
		op = op_t'($urandom_range(0, 99) < remove_pct);
		put_item(op, random_key(), NB'($urandom()), NB'($urandom()));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_item(OP_REMOVE, '0, '0, '0);
		put_item(OP_INSERT, 32'h0000_0000, 16'h0000, 16'h0000);
		put_item(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
		put_item(OP_INSERT, 32'h8000_0000, 16'hFFFF, 16'h0000);
		put_item(OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
		put_item(OP_INSERT, 32'd5, 16'h0001, 16'h0001);
		put_item(OP_INSERT, 32'd5, 16'h0002, 16'h0002);
		put_item(OP_INSERT, 32'd5, 16'h0003, 16'h0003);
		put_item(OP_INSERT, 32'd5, 16'h0004, 16'h0004);
		put_item(OP_INSERT, 32'd1, 16'hAAAA, 16'h5555);
		repeat (10)
			put_item(OP_REMOVE, random_key(), NB'($urandom()), NB'($urandom()));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 180 && i < 300);
			if (i < 150)
				put_random_item(30);
			else if (i < 300)
				put_random_item(50);
			else
				put_random_item(70);
		end
		steady = 1'b0;

		// Drain the heap and push past empty.
		while (sb.held > 0)
			put_random_item(100);
		repeat (2)
			put_random_item(100);

		start <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== binary_min_heap_queue.f =====
src/hbq_pkg.sv
src/hbq_mem.sv
src/hbq_cmp.sv
src/binary_min_heap_queue.sv
tb/tb_binary_min_heap_queue.sv
